// ----- rtl/core/isotp_rr_pkg.sv -----
// isotp_rr_pkg: shared types and constants of the isotp response reassembler
// used by the interfaces' companions, the control and beat output modules and the top level
package isotp_rr_pkg;

   localparam logic [12:0] BUFFER_BYTES        = 13'd4096;
   localparam logic [7:0]  PENDING_LIMIT_RESET = 8'd200;

   localparam logic [7:0]  PCI_NEG_LEN   = 8'h03;
   localparam logic [7:0]  SID_NEGATIVE  = 8'h7F;
   localparam logic [7:0]  NRC_PENDING   = 8'h78;
   localparam int unsigned PCI_FF_BIT    = 4;
   localparam logic [7:0]  SF_MAX_LEN    = 8'd7;
   localparam logic [11:0] FF_BYTES      = 12'd6;
   localparam logic [11:0] CF_BYTES      = 12'd7;
   localparam logic [11:0] NEG_LEN       = 12'd3;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PEND  = 3'b010,
      PH_MULTI = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_NEG = 2'd1,
      ST_TMO = 2'd2
   } status_type;

   typedef struct packed {
      logic            operation;
      logic [7:0]      buffer_slot;
      logic [7:0][7:0] frame;
   } item_type;

   typedef struct packed {
      logic [7:0]      slot;
      logic [11:0]     total;
      logic [11:0]     base;
      logic [6:0][7:0] bytes;
      logic            wr;
      logic [2:0]      nres;
      logic            done;
      status_type      status;
   } burst_type;

endpackage

// ----- rtl/core/isotp_rr_if.sv -----
// isotp_rr_req_if / isotp_rr_rsp_if: valid-ready channels of the reassembler
// plain interfaces, no package dependency
interface isotp_rr_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] buffer_slot;
   logic [7:0] frame_byte_0;
   logic [7:0] frame_byte_1;
   logic [7:0] frame_byte_2;
   logic [7:0] frame_byte_3;
   logic [7:0] frame_byte_4;
   logic [7:0] frame_byte_5;
   logic [7:0] frame_byte_6;
   logic [7:0] frame_byte_7;

   modport source (
      output valid, operation, buffer_slot, frame_byte_0, frame_byte_1, frame_byte_2,
             frame_byte_3, frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7,
      input  ready
   );
   modport sink (
      input  valid, operation, buffer_slot, frame_byte_0, frame_byte_1, frame_byte_2,
             frame_byte_3, frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7,
      output ready
   );
endinterface

interface isotp_rr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  dest_slot;
   logic        write_valid;
   logic [11:0] byte_index;
   logic [7:0]  byte_value;
   logic        done_res;
   logic [1:0]  status;
   logic [11:0] total_length;
   logic        last;

   modport source (
      output valid, dest_slot, write_valid, byte_index, byte_value, done_res, status,
             total_length, last,
      input  ready
   );
   modport sink (
      input  valid, dest_slot, write_valid, byte_index, byte_value, done_res, status,
             total_length, last,
      output ready
   );
endinterface

// ----- rtl/core/isotp_response_reassembler_top.sv -----
// isotp_response_reassembler_top: input register, pending limit register, control and beat output
// depends on isotp_rr_pkg, isotp_rr_if, isotp_rr_ctrl and isotp_rr_emit
//
// A frame beat waits in the input register until the result register can take it. It is
// decided there in one pass against the reassembly state and handed over as a burst of one to
// seven beats (one per stored byte, or one status beat); a response-pending frame gives none
// unless it brings the pending count to the limit, when it gives one timeout status beat. The
// result port gives one beat per cycle while the receiver is ready. The next frame is decided
// in the cycle that the last beat of the previous one is accepted, so back-to-back frames that
// give beats keep the result port busy without a gap.
module isotp_response_reassembler_top (
   input  logic           clock,
   input  logic           reset,
   isotp_rr_req_if.sink   req_bus,
   isotp_rr_rsp_if.source rsp_bus,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data
);
   import isotp_rr_pkg::*;

   logic      in_valid_ff;
   item_type  in_item_ff;
   logic [7:0] limit_ff;
   burst_type burst;
   logic      has_res, load_ok, advance;

   assign advance       = in_valid_ff && load_ok;
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         limit_ff    <= PENDING_LIMIT_RESET;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.operation   <= req_bus.operation;
         in_item_ff.buffer_slot <= req_bus.buffer_slot;
         in_item_ff.frame       <= {req_bus.frame_byte_7, req_bus.frame_byte_6,
                                    req_bus.frame_byte_5, req_bus.frame_byte_4,
                                    req_bus.frame_byte_3, req_bus.frame_byte_2,
                                    req_bus.frame_byte_1, req_bus.frame_byte_0};
      end
   end

   isotp_rr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .item          (in_item_ff),
      .advance       (advance),
      .pending_limit (limit_ff),
      .burst         (burst),
      .has_res       (has_res)
   );

   isotp_rr_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .burst   (burst),
      .load    (advance && has_res),
      .load_ok (load_ok),
      .rsp     (rsp_bus)
   );

   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.done_res |-> rsp_bus.last)
      else $error("done beat is not the last beat of its frame");

   a_status_only_done : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.done_res |-> rsp_bus.status == ST_OK)
      else $error("status set on a beat that does not finish the response");

   a_nowrite_single : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.write_valid |-> rsp_bus.last)
      else $error("status-only beat is not alone");

   a_index_steps : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.write_valid && !rsp_bus.last
      |=> rsp_bus.valid && rsp_bus.byte_index == $past(rsp_bus.byte_index) + 12'd1)
      else $error("byte index does not advance by one within a burst");

endmodule

// ----- rtl/core/isotp_rr_ctrl.sv -----
// isotp_rr_ctrl: reassembly state and per-frame decision logic
// depends on isotp_rr_pkg
module isotp_rr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  isotp_rr_pkg::item_type  item,
   input  logic                  advance,
   input  logic [7:0]            pending_limit,
   output isotp_rr_pkg::burst_type burst,
   output logic                  has_res
);
   import isotp_rr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [11:0] exp_ff, exp_in;
   logic [11:0] stored_ff, stored_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  held_ff, held_in;

   logic            carry, is_neg, is_pend, use_hi;
   logic [11:0]     exp_cur, rem;
   logic [12:0]     ff_len;
   logic [7:0]      sf_len;
   logic [2:0]      nwrite;
   logic [6:0][7:0] sel_lo, sel_hi;

   always_comb begin
      for (int k = 0; k < 7; k++) begin
         sel_lo[k] = item.frame[k + 1];
         sel_hi[k] = (k < 6) ? item.frame[(k + 2) % 8] : 8'd0;
      end
   end

   always_comb begin
      carry   = (phase_ff == PH_PEND) || (phase_ff == PH_MULTI);
      exp_cur = carry ? exp_ff : 12'd0;
      is_neg  = (item.frame[0] == PCI_NEG_LEN) && (item.frame[1] == SID_NEGATIVE);
      is_pend = is_neg && (item.frame[3] == NRC_PENDING);
      rem     = exp_ff - stored_ff;
      sf_len  = (item.frame[0] > SF_MAX_LEN) ? SF_MAX_LEN : item.frame[0];
      ff_len  = {1'b0, item.frame[0][3:0], item.frame[1]};
      if (ff_len > BUFFER_BYTES) begin
         ff_len = BUFFER_BYTES;
      end

      phase_in  = carry ? phase_ff : PH_IDLE;
      held_in   = carry ? held_ff : item.buffer_slot;
      exp_in    = exp_cur;
      stored_in = stored_ff;
      pend_in   = pend_ff;
      has_res   = 1'b1;
      use_hi    = 1'b0;
      nwrite    = 3'd0;
      burst     = '0;
      burst.status = ST_OK;

      if (item.operation) begin
         burst.done   = 1'b1;
         burst.status = ST_TMO;
         phase_in     = PH_IDLE;
      end else if (phase_ff == PH_MULTI) begin
         nwrite    = (rem < CF_BYTES) ? rem[2:0] : 3'd7;
         stored_in = stored_ff + {9'd0, nwrite};
         if (nwrite == 3'd0) begin
            burst.done = 1'b1;
            phase_in   = PH_IDLE;
         end else begin
            burst.base = stored_ff;
            if (stored_in >= exp_ff) begin
               burst.done = 1'b1;
               phase_in   = PH_IDLE;
            end
         end
      end else if (is_pend && (phase_ff == PH_PEND)) begin
         pend_in = pend_ff + 8'd1;
         if (pend_in >= pending_limit) begin
            burst.done   = 1'b1;
            burst.status = ST_TMO;
            phase_in     = PH_IDLE;
         end else begin
            has_res = 1'b0;
         end
      end else if (is_pend) begin
         phase_in = PH_PEND;
         pend_in  = 8'd0;
         has_res  = 1'b0;
      end else if (is_neg) begin
         exp_in       = NEG_LEN;
         nwrite       = 3'd3;
         burst.done   = 1'b1;
         burst.status = ST_NEG;
         phase_in     = PH_IDLE;
      end else if (!item.frame[0][PCI_FF_BIT]) begin
         exp_in     = {4'd0, sf_len};
         nwrite     = sf_len[2:0];
         burst.done = 1'b1;
         phase_in   = PH_IDLE;
      end else begin
         exp_in = ff_len[11:0];
         use_hi = 1'b1;
         nwrite = (ff_len[11:0] < FF_BYTES) ? ff_len[2:0] : 3'd6;
         if (ff_len[11:0] <= FF_BYTES) begin
            burst.done = 1'b1;
            phase_in   = PH_IDLE;
         end else begin
            stored_in = FF_BYTES;
            phase_in  = PH_MULTI;
         end
      end

      burst.slot  = held_in;
      burst.total = exp_in;
      burst.wr    = (nwrite != 3'd0);
      burst.nres  = (nwrite == 3'd0) ? 3'd1 : nwrite;
      if (nwrite != 3'd0) begin
         burst.bytes = use_hi ? sel_hi : sel_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         exp_ff    <= '0;
         stored_ff <= '0;
         pend_ff   <= '0;
         held_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         exp_ff    <= exp_in;
         stored_ff <= stored_in;
         pend_ff   <= pend_in;
         held_ff   <= held_in;
      end
   end

endmodule

// ----- rtl/core/isotp_rr_emit.sv -----
// isotp_rr_emit: result register that plays a burst out one beat per cycle while the receiver is ready
// depends on isotp_rr_pkg and isotp_rr_rsp_if
module isotp_rr_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  isotp_rr_pkg::burst_type burst,
   input  logic                    load,
   output logic                    load_ok,
   isotp_rr_rsp_if.source          rsp
);
   import isotp_rr_pkg::*;

   logic            busy_ff, busy_in;
   logic [2:0]      rem_ff, rem_in;
   logic [11:0]     base_ff, base_in;
   logic [6:0][7:0] bytes_ff, bytes_in;
   logic            wr_ff;
   logic [7:0]      slot_ff;
   logic [11:0]     total_ff;
   logic            done_ff;
   status_type      status_ff;
   logic            is_last, beat;

   assign is_last = (rem_ff == 3'd1);
   assign beat    = busy_ff && rsp.ready;
   assign load_ok = !busy_ff || (rsp.ready && is_last);

   always_comb begin
      busy_in  = busy_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      bytes_in = bytes_ff;
      if (load) begin
         busy_in  = 1'b1;
         rem_in   = burst.nres;
         base_in  = burst.base;
         bytes_in = burst.bytes;
      end else if (beat) begin
         busy_in  = !is_last;
         rem_in   = rem_ff - 3'd1;
         base_in  = base_ff + 12'd1;
         bytes_in = {8'd0, bytes_ff[6:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      bytes_ff <= bytes_in;
      if (load) begin
         wr_ff     <= burst.wr;
         slot_ff   <= burst.slot;
         total_ff  <= burst.total;
         done_ff   <= burst.done;
         status_ff <= burst.status;
      end
   end

   assign rsp.valid        = busy_ff;
   assign rsp.dest_slot    = slot_ff;
   assign rsp.write_valid  = wr_ff;
   assign rsp.byte_index   = wr_ff ? base_ff : 12'd0;
   assign rsp.byte_value   = wr_ff ? bytes_ff[0] : 8'd0;
   assign rsp.done_res     = is_last && done_ff;
   assign rsp.status       = (is_last && done_ff) ? status_ff : ST_OK;
   assign rsp.total_length = total_ff;
   assign rsp.last         = is_last;

endmodule

// ----- test/isotp_rr_tb_pkg.sv -----
`timescale 1ns / 1ps
// isotp_rr_tb_pkg: operation codes of a request beat, shared by the testbench files
// no dependencies
package isotp_rr_tb_pkg;

   localparam logic OP_FRAME   = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

endpackage

// ----- test/isotp_rr_reassembly_check.sv -----
`timescale 1ns / 1ps
// isotp_rr_reassembly_check: watches both channels and the pending limit write, predicts the
// buffer writes of every accepted frame and compares them with the result beats
// depends on isotp_rr_pkg, isotp_rr_tb_pkg and the isotp_rr_req_if / isotp_rr_rsp_if interfaces
module isotp_rr_reassembly_check (
   input  logic       clock,
   input  logic       reset,
   isotp_rr_req_if    req_mon,
   isotp_rr_rsp_if    rsp_mon,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         mismatches,
   output int         beats_owed
);
   import isotp_rr_pkg::*;
   import isotp_rr_tb_pkg::*;

   typedef struct packed {
      logic [7:0]  dest_slot;
      logic        write_valid;
      logic [11:0] byte_index;
      logic [7:0]  byte_value;
      logic        done_res;
      status_type  status;
      logic [11:0] total_length;
      logic        last;
   } buffer_write_type;

   buffer_write_type owed_beats[$];
   buffer_write_type step_beats[$];

   phase_type   phase;
   logic [11:0] resp_len;
   logic [11:0] stored;
   logic [7:0]  pend_count;
   logic [7:0]  slot_held;
   logic [7:0]  pend_limit;

   function automatic void push_beat(logic wr, int idx, logic [7:0] val);
      buffer_write_type b;
      b              = '0;
      b.dest_slot    = slot_held;
      b.write_valid  = wr;
      b.byte_index   = wr ? 12'(idx) : 12'd0;
      b.byte_value   = wr ? val : 8'd0;
      b.total_length = resp_len;
      step_beats.push_back(b);
   endfunction

   function automatic void close_step(logic done, status_type st);
      buffer_write_type tail;
      tail          = step_beats[step_beats.size() - 1];
      tail.last     = 1'b1;
      tail.done_res = done;
      tail.status   = done ? st : ST_OK;
      step_beats[step_beats.size() - 1] = tail;
      if (done) phase = PH_IDLE;
      foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
      step_beats.delete();
   endfunction

   function automatic void store_negative(logic [7:0] b [8]);
      resp_len = NEG_LEN;
      for (int i = 0; i < 3; i++) push_beat(1'b1, i, b[1 + i]);
      close_step(1'b1, ST_NEG);
   endfunction

   function automatic void start_response(logic [7:0] b [8]);
      int len;
      int n;
      if (!b[0][PCI_FF_BIT]) begin
         len = (b[0] > SF_MAX_LEN) ? SF_MAX_LEN : b[0];
         resp_len = 12'(len);
         if (len == 0) begin
            push_beat(1'b0, 0, 8'd0);
            close_step(1'b1, ST_OK);
         end else begin
            for (int i = 0; i < len; i++) push_beat(1'b1, i, b[1 + i]);
            close_step(1'b1, ST_OK);
         end
      end else begin
         len = int'({b[0][3:0], b[1]});
         if (len > int'(BUFFER_BYTES)) len = int'(BUFFER_BYTES);
         resp_len = 12'(len);
         if (len == 0) begin
            push_beat(1'b0, 0, 8'd0);
            close_step(1'b1, ST_OK);
         end else begin
            n = (len < FF_BYTES) ? len : FF_BYTES;
            for (int i = 0; i < n; i++) push_beat(1'b1, i, b[2 + i]);
            if (len <= FF_BYTES) begin
               close_step(1'b1, ST_OK);
            end else begin
               stored = FF_BYTES;
               phase  = PH_MULTI;
               close_step(1'b0, ST_OK);
            end
         end
      end
   endfunction

   function automatic void reassemble_frame(logic op, logic [7:0] slot, logic [7:0] b [8]);
      logic is_neg;
      logic is_pend;
      int   n;
      if (phase != PH_PEND && phase != PH_MULTI) begin
         phase     = PH_IDLE;
         slot_held = slot;
         resp_len  = '0;
      end
      if (op == OP_TIMEOUT) begin
         push_beat(1'b0, 0, 8'd0);
         close_step(1'b1, ST_TMO);
         return;
      end
      is_neg  = (b[0] == PCI_NEG_LEN) && (b[1] == SID_NEGATIVE);
      is_pend = is_neg && (b[3] == NRC_PENDING);
      case (phase)
         PH_MULTI: begin
            n = resp_len - stored;
            if (n > CF_BYTES) n = CF_BYTES;
            for (int i = 0; i < n; i++) push_beat(1'b1, stored + i, b[1 + i]);
            stored = stored + 12'(n);
            if (n == 0) begin
               push_beat(1'b0, 0, 8'd0);
               close_step(1'b1, ST_OK);
            end else begin
               close_step(stored >= resp_len, ST_OK);
            end
         end
         PH_PEND: begin
            if (is_pend) begin
               pend_count = pend_count + 8'd1;
               if (pend_count >= pend_limit) begin
                  push_beat(1'b0, 0, 8'd0);
                  close_step(1'b1, ST_TMO);
               end
            end else if (is_neg) begin
               store_negative(b);
            end else begin
               phase = PH_IDLE;
               start_response(b);
            end
         end
         default: begin
            if (is_pend) begin
               phase      = PH_PEND;
               pend_count = '0;
            end else if (is_neg) begin
               store_negative(b);
            end else begin
               start_response(b);
            end
         end
      endcase
   endfunction

   function automatic void compare_field(string field, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : track
      logic [7:0]       frame [8];
      buffer_write_type want;
      if (reset) begin
         phase      = PH_IDLE;
         resp_len   = '0;
         stored     = '0;
         pend_count = '0;
         slot_held  = '0;
         pend_limit = PENDING_LIMIT_RESET;
         mismatches = 0;
         owed_beats.delete();
      end else begin
         if (csr_wr_en) pend_limit = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            frame[0] = req_mon.frame_byte_0;
            frame[1] = req_mon.frame_byte_1;
            frame[2] = req_mon.frame_byte_2;
            frame[3] = req_mon.frame_byte_3;
            frame[4] = req_mon.frame_byte_4;
            frame[5] = req_mon.frame_byte_5;
            frame[6] = req_mon.frame_byte_6;
            frame[7] = req_mon.frame_byte_7;
            reassemble_frame(req_mon.operation, req_mon.buffer_slot, frame);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_beats.size() == 0) begin
               $error("result beat with nothing expected: slot %0d index %0d value %0d",
                      rsp_mon.dest_slot, rsp_mon.byte_index, rsp_mon.byte_value);
               mismatches++;
            end else begin
               want = owed_beats.pop_front();
               compare_field("dest_slot", want.dest_slot, rsp_mon.dest_slot);
               compare_field("write_valid", want.write_valid, rsp_mon.write_valid);
               compare_field("byte_index", want.byte_index, rsp_mon.byte_index);
               compare_field("byte_value", want.byte_value, rsp_mon.byte_value);
               compare_field("done_res", want.done_res, rsp_mon.done_res);
               compare_field("status", int'(want.status), int'(rsp_mon.status));
               compare_field("total_length", want.total_length, rsp_mon.total_length);
               compare_field("last", want.last, rsp_mon.last);
            end
         end
      end
      beats_owed <= owed_beats.size();
   end

endmodule

// ----- test/tb_isotp_response_reassembler_top.sv -----
`timescale 1ns / 1ps
// tb_isotp_response_reassembler_top: clock, reset, frame stimulus, result back-pressure and verdict
// depends on isotp_rr_pkg, isotp_rr_tb_pkg, the channel interfaces, isotp_rr_reassembly_check
// and isotp_response_reassembler_top
module tb_isotp_response_reassembler_top;
   import isotp_rr_pkg::*;
   import isotp_rr_tb_pkg::*;

   localparam int QUIET_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 24;
   localparam int PHASE_FRAMES    = 25;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   int         mismatches;
   int         beats_owed;
   int         frames_sent;
   int         limit_now;
   bit         send_idle;
   bit         recv_idle;
   bit         hold_off_now;

   isotp_rr_req_if req_ch ();
   isotp_rr_rsp_if rsp_ch ();

   isotp_response_reassembler_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   isotp_rr_reassembly_check i_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .beats_owed  (beats_owed)
   );

   always #5 clock = ~clock;

   // pdu[63:56] is frame byte 0
   task automatic send_frame(input logic op, input logic [7:0] slot, input logic [63:0] pdu);
      int gap;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.buffer_slot  <= slot;
      req_ch.frame_byte_0 <= pdu[63:56];
      req_ch.frame_byte_1 <= pdu[55:48];
      req_ch.frame_byte_2 <= pdu[47:40];
      req_ch.frame_byte_3 <= pdu[39:32];
      req_ch.frame_byte_4 <= pdu[31:24];
      req_ch.frame_byte_5 <= pdu[23:16];
      req_ch.frame_byte_6 <= pdu[15:8];
      req_ch.frame_byte_7 <= pdu[7:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      frames_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [63:0] pending_pdu();
      logic [63:0] pdu;
      pdu = {$urandom, $urandom};
      pdu[63:48] = {PCI_NEG_LEN, SID_NEGATIVE};
      pdu[39:32] = NRC_PENDING;
      return pdu;
   endfunction

   function automatic logic [63:0] negative_pdu();
      logic [63:0] pdu;
      pdu = {$urandom, $urandom};
      pdu[63:48] = {PCI_NEG_LEN, SID_NEGATIVE};
      if (pdu[39:32] == NRC_PENDING) pdu[32] = ~pdu[32];
      return pdu;
   endfunction

   task automatic send_response();
      logic [7:0]  slot;
      logic [63:0] pdu;
      int          len;
      int          count;
      int          cut;
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      slot = 8'($urandom);
      pdu  = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: begin
            if ($urandom_range(0, 3) == 0) pdu[63:56] = 8'($urandom) & 8'hEF;
            else pdu[63:56] = 8'($urandom_range(0, 7));
            send_frame(OP_FRAME, slot, pdu);
         end
         1: send_frame(OP_FRAME, slot, negative_pdu());
         2, 3: begin
            send_frame(OP_FRAME, slot, pending_pdu());
            count = $urandom_range(0, (limit_now < 8) ? limit_now + 1 : 8);
            repeat (count) send_frame(OP_FRAME, 8'($urandom), pending_pdu());
            case ($urandom_range(0, 3))
               0: send_frame(OP_FRAME, 8'($urandom), negative_pdu());
               1: send_frame(OP_TIMEOUT, 8'($urandom), pdu);
               2: begin
                  pdu[63:56] = 8'($urandom_range(0, 7));
                  send_frame(OP_FRAME, 8'($urandom), pdu);
               end
               default: ;
            endcase
         end
         4, 5, 6: begin
            case ($urandom_range(0, 7))
               0: len = $urandom_range(0, 4095);
               1: len = $urandom_range(0, 6);
               default: len = $urandom_range(7, 40);
            endcase
            pdu[63:48] = {3'($urandom), 1'b1, 4'(len >> 8), 8'(len)};
            send_frame(OP_FRAME, slot, pdu);
            count = (len > 6) ? (len - 6 + 6) / 7 : 0;
            cut   = (len > 60 || $urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : count;
            for (int i = 0; i < count && i < cut; i++) begin
               pdu = {$urandom, $urandom};
               if ($urandom_range(0, 3) != 0) pdu[63:56] = {4'h2, 4'(i + 1)};
               send_frame(OP_FRAME, 8'($urandom), pdu);
            end
            if (cut < count) send_frame(OP_TIMEOUT, 8'($urandom), {$urandom, $urandom});
         end
         7: send_frame(OP_TIMEOUT, slot, pdu);
         default: send_frame(($urandom_range(0, 7) == 0) ? OP_TIMEOUT : OP_FRAME, slot, pdu);
      endcase
   endtask

   initial begin : receiver
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         if (hold_off_now) begin
            rsp_ch.ready <= 1'b0;
            hold_off_now = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         stall = recv_idle ? $urandom_range(0, 8) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("isotp_response_reassembler_top verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] pdu;
      int          target;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 8'd0;
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_FRAME;
      req_ch.buffer_slot  = 8'd0;
      req_ch.frame_byte_0 = 8'd0;
      req_ch.frame_byte_1 = 8'd0;
      req_ch.frame_byte_2 = 8'd0;
      req_ch.frame_byte_3 = 8'd0;
      req_ch.frame_byte_4 = 8'd0;
      req_ch.frame_byte_5 = 8'd0;
      req_ch.frame_byte_6 = 8'd0;
      req_ch.frame_byte_7 = 8'd0;
      frames_sent  = 0;
      limit_now    = PENDING_LIMIT_RESET;
      send_idle    = 1'b1;
      recv_idle    = 1'b1;
      hold_off_now = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed frames under the reset pending limit
      send_frame(OP_FRAME, 8'h00, 64'h00_00_00_00_00_00_00_00);
      send_frame(OP_FRAME, 8'hFF, 64'h07_11_22_33_44_55_66_77);
      send_frame(OP_FRAME, 8'h5A, 64'hEF_FF_FE_FD_FC_FB_FA_F9);
      send_frame(OP_FRAME, 8'h01, 64'h03_7F_22_31_AA_AA_AA_AA);
      send_frame(OP_FRAME, 8'h11, 64'h03_7F_22_78_00_00_00_00);
      send_frame(OP_FRAME, 8'h22, 64'h03_7F_22_78_FF_FF_FF_FF);
      send_frame(OP_FRAME, 8'h23, 64'h03_7F_22_13_55_55_55_55);
      send_frame(OP_FRAME, 8'h33, 64'h03_7F_19_78_00_00_00_00);
      send_frame(OP_FRAME, 8'h44, 64'h05_62_F1_90_41_42_00_00);
      send_frame(OP_FRAME, 8'h45, 64'h03_7F_10_78_12_34_56_78);
      send_frame(OP_TIMEOUT, 8'h55, 64'h00_00_00_00_00_00_00_00);
      send_frame(OP_TIMEOUT, 8'hFF, 64'hFF_FF_FF_FF_FF_FF_FF_FF);
      send_frame(OP_FRAME, 8'h66, 64'h10_00_01_02_03_04_05_06);
      send_frame(OP_FRAME, 8'h67, 64'h10_06_A1_A2_A3_A4_A5_A6);
      send_frame(OP_FRAME, 8'h68, 64'h10_03_B1_B2_B3_00_00_00);
      send_frame(OP_FRAME, 8'h77, 64'h10_14_C1_C2_C3_C4_C5_C6);
      send_frame(OP_FRAME, 8'h78, 64'h21_D1_D2_D3_D4_D5_D6_D7);
      send_frame(OP_FRAME, 8'h79, 64'h22_E1_E2_E3_E4_E5_E6_E7);
      send_frame(OP_FRAME, 8'h88, 64'h10_08_01_02_03_04_05_06);
      send_frame(OP_FRAME, 8'h89, 64'h03_7F_22_78_00_00_00_00);
      send_frame(OP_FRAME, 8'h99, 64'hFF_FF_80_81_82_83_84_85);
      send_frame(OP_FRAME, 8'h9A, 64'h21_00_FF_00_FF_00_FF_00);
      send_frame(OP_TIMEOUT, 8'h9B, 64'h21_00_00_00_00_00_00_00);
      send_frame(OP_FRAME, 8'hAA, 64'h21_91_92_93_94_95_96_97);
      send_frame(OP_FRAME, 8'hBB, 64'h03_7E_01_02_03_04_05_06);

      // pending wait run out to the limit: one opening frame and twelve more
      drain();
      set_limit(8'd12);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      repeat (13) send_frame(OP_FRAME, 8'hA5, pending_pdu());

      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: set_limit(8'd1);
            1: set_limit(8'($urandom_range(2, 6)));
            2: set_limit(8'($urandom_range(7, 254)));
            default: set_limit(8'd255);
         endcase
         if (p == 1) begin
            hold_off_now = 1'b1;
            send_idle    = 1'b0;
            repeat (4) begin
               pdu = {$urandom, $urandom};
               pdu[63:48] = {8'h10, 8'd34};
               send_frame(OP_FRAME, 8'($urandom), pdu);
               for (int i = 0; i < 4; i++) send_frame(OP_FRAME, 8'h00, {$urandom, $urandom});
            end
         end
         target = frames_sent + PHASE_FRAMES;
         while (frames_sent < target) send_response();
      end

      // one long response, carried to completion
      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_frame(OP_FRAME, 8'hC3, 64'h10_5B_01_02_03_04_05_06);
      for (int i = 0; i < 13; i++)
         send_frame(OP_FRAME, 8'h3C, {8'h20 | 8'((i + 1) & 15), $urandom, 24'($urandom)});

      drain();
      if (mismatches == 0) begin
         $display("isotp_response_reassembler_top verification clean");
      end else begin
         $display("isotp_response_reassembler_top verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/isotp_rr_pkg.sv
rtl/core/isotp_rr_if.sv
rtl/core/isotp_rr_ctrl.sv
rtl/core/isotp_rr_emit.sv
rtl/core/isotp_response_reassembler_top.sv
test/isotp_rr_tb_pkg.sv
test/isotp_rr_reassembly_check.sv
test/tb_isotp_response_reassembler_top.sv
